/* hdl/mfv_pkg.sv */
package mfv_pkg;

  // Format limits
  localparam logic [15:0] MAX_ENTRIES    = 16'd256;
  localparam logic [15:0] NAME_MAX_BYTES = 16'd63;
  localparam logic [15:0] PATH_MAX_BYTES = 16'd255;
  localparam logic [15:0] KEY_MAX_BYTES  = 16'd127;
  localparam logic [15:0] CID_BYTES      = 16'd32;
  localparam logic [15:0] MAGIC_LEN      = 16'd6;
  localparam logic [15:0] VERSION_BYTES  = 16'd8;
  localparam logic [15:0] SIZE_BYTES     = 16'd8;

  // Prior path store
  localparam int          STORE_DEPTH = 255;
  localparam int          STORE_AW    = $clog2(STORE_DEPTH);
  localparam logic [15:0] STORE_LIMIT = 16'(STORE_DEPTH);

  // Field kind codes as seen on out_tuser
  localparam logic [3:0] KIND_MAGIC    = 4'd0;
  localparam logic [3:0] KIND_VERSION  = 4'd1;
  localparam logic [3:0] KIND_NAME_LEN = 4'd2;
  localparam logic [3:0] KIND_NAME     = 4'd3;
  localparam logic [3:0] KIND_COUNT    = 4'd4;
  localparam logic [3:0] KIND_PATH_LEN = 4'd5;
  localparam logic [3:0] KIND_PATH     = 4'd6;
  localparam logic [3:0] KIND_KEY_LEN  = 4'd7;
  localparam logic [3:0] KIND_KEY      = 4'd8;
  localparam logic [3:0] KIND_SIZE     = 4'd9;
  localparam logic [3:0] KIND_CID      = 4'd10;
  localparam logic [3:0] KIND_EXCESS   = 4'd11;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_VALID = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Output payload layout
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 4;

  // Parser phase, one-hot
  typedef enum logic [11:0] {
    PH_MAGIC    = 12'b0000_0000_0001,
    PH_VERSION  = 12'b0000_0000_0010,
    PH_NAME_LEN = 12'b0000_0000_0100,
    PH_NAME     = 12'b0000_0000_1000,
    PH_COUNT    = 12'b0000_0001_0000,
    PH_PATH_LEN = 12'b0000_0010_0000,
    PH_PATH     = 12'b0000_0100_0000,
    PH_KEY_LEN  = 12'b0000_1000_0000,
    PH_KEY      = 12'b0001_0000_0000,
    PH_SIZE     = 12'b0010_0000_0000,
    PH_CID      = 12'b0100_0000_0000,
    PH_EXCESS   = 12'b1000_0000_0000
  } phase_t;

  // Path order compare result
  typedef enum logic [1:0] {
    V_OPEN    = 2'd0,
    V_LESS    = 2'd1,
    V_GREATER = 2'd2,
    V_EQUAL   = 2'd3
  } verdict_t;

  // Expected magic byte at a position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h4D;  // M
      3'd1:    b = 8'h33;  // 3
      3'd2:    b = 8'h52;  // R
      3'd3:    b = 8'h45;  // E
      3'd4:    b = 8'h4C;  // L
      3'd5:    b = 8'h31;  // 1
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Field kind tag of a phase
  function automatic logic [3:0] phase_kind(input phase_t ph);
    logic [3:0] k;
    unique case (ph)
      PH_MAGIC:    k = KIND_MAGIC;
      PH_VERSION:  k = KIND_VERSION;
      PH_NAME_LEN: k = KIND_NAME_LEN;
      PH_NAME:     k = KIND_NAME;
      PH_COUNT:    k = KIND_COUNT;
      PH_PATH_LEN: k = KIND_PATH_LEN;
      PH_PATH:     k = KIND_PATH;
      PH_KEY_LEN:  k = KIND_KEY_LEN;
      PH_KEY:      k = KIND_KEY;
      PH_SIZE:     k = KIND_SIZE;
      PH_CID:      k = KIND_CID;
      default:     k = KIND_EXCESS;
    endcase
    return k;
  endfunction

endpackage

/* hdl/manifest_stream_validator.sv */
// Manifest stream validator.
// Input channel in_*: one manifest byte per request in in_tdata, in_tlast on
// the final byte of a manifest. Output channel out_*: one result per input
// byte, carrying the byte, its entry index and a running status, with the
// field kind in out_tuser. Status reads 0 while the manifest is fine so far,
// 1 on the last byte of a complete and valid manifest, 2 once any check has
// failed (sticky until the last byte).
// Throughput is one byte per cycle unless the output stalls; the result is
// registered in the cycle after the byte is taken. The rate is set by the
// prior-path store, a single RAM with one write and one registered read per
// cycle; the next byte's read is issued with the current one's state update.
// Reset clears the parser to the start of a manifest and empties the output
// register; the path store needs no clearing, only bytes of the previous path
// in the same manifest are ever read. The parser also returns to the start
// after every byte marked in_tlast.
// When the receiver stalls, the result holds in the output register and
// in_tready drops only while that register is full and not being taken.
module manifest_stream_validator (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input requests
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // end_of_stream
  // Result requests
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mfv_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] byte_value,
                                                     // [15:8] entry_number,
                                                     // [17:16] status
  output logic [mfv_pkg::OUT_USER_W-1:0] out_tuser   // [3:0] field_kind
);

  import mfv_pkg::*;

  phase_t        phase_r, phase_nxt;
  logic [15:0]   bif_r, bif_nxt;
  logic [15:0]   field_len_r, field_len_nxt;
  logic [15:0]   expected_r, expected_nxt;
  logic [8:0]    entry_cnt_r, entry_cnt_nxt;
  logic [7:0]    prior_len_r, prior_len_nxt;
  verdict_t      verdict_r, verdict_nxt;
  logic          error_r, error_nxt;

  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic          accept;
  logic [7:0]    b;
  logic [3:0]    kind;
  logic [7:0]    ent;
  logic [1:0]    status;
  logic          store_we;
  logic [7:0]    store_rdata;
  logic [STORE_AW-1:0] store_raddr;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign b         = in_tdata;

  // Parser next state for the byte on the input
  always_comb begin
    logic [15:0] bif_inc;
    logic [15:0] len;
    logic [7:0]  p;
    logic        fail;
    verdict_t    v_mid;
    logic [15:0] exp_dec;

    phase_nxt     = phase_r;
    bif_nxt       = bif_r;
    field_len_nxt = field_len_r;
    expected_nxt  = expected_r;
    entry_cnt_nxt = entry_cnt_r;
    prior_len_nxt = prior_len_r;
    verdict_nxt   = verdict_r;
    error_nxt     = error_r;
    store_we      = 1'b0;
    fail          = 1'b0;

    bif_inc = bif_r + 16'd1;
    len     = field_len_r | {8'h00, b};
    exp_dec = expected_r - 16'd1;
    p       = ((bif_r < {8'h00, prior_len_r}) && (bif_r < STORE_LIMIT)) ? store_rdata : 8'h00;
    v_mid   = verdict_r;
    if (verdict_r == V_OPEN) begin
      if (b != p) begin
        v_mid = (b < p) ? V_LESS : V_GREATER;
      end else if (b == 8'h00) begin
        v_mid = V_EQUAL;
      end
    end

    kind = phase_kind(phase_r);
    ent  = (phase_r == PH_PATH_LEN || phase_r == PH_PATH || phase_r == PH_KEY_LEN ||
            phase_r == PH_KEY || phase_r == PH_SIZE || phase_r == PH_CID)
           ? entry_cnt_r[7:0] : 8'h00;

    unique case (phase_r)
      PH_MAGIC: begin
        if (bif_r >= MAGIC_LEN || b != magic_byte(bif_r[2:0])) begin
          fail = 1'b1;
        end else if (bif_inc == MAGIC_LEN) begin
          phase_nxt = PH_VERSION;
          bif_nxt   = '0;
        end else begin
          bif_nxt = bif_inc;
        end
      end
      PH_VERSION: begin
        if (bif_inc >= VERSION_BYTES) begin
          phase_nxt = PH_NAME_LEN;
          bif_nxt   = '0;
        end else begin
          bif_nxt = bif_inc;
        end
      end
      PH_NAME_LEN, PH_COUNT, PH_PATH_LEN, PH_KEY_LEN: begin
        if (bif_r == 16'd0) begin
          // High byte of a big-endian length
          field_len_nxt = {b, 8'h00};
          bif_nxt       = 16'd1;
        end else begin
          bif_nxt = '0;
          unique case (phase_r)
            PH_NAME_LEN: begin
              if (len == 16'd0 || len > NAME_MAX_BYTES) begin
                fail = 1'b1;
              end else begin
                field_len_nxt = len;
                phase_nxt     = PH_NAME;
              end
            end
            PH_COUNT: begin
              if (len > MAX_ENTRIES) begin
                fail = 1'b1;
              end else begin
                expected_nxt  = len;
                entry_cnt_nxt = '0;
                prior_len_nxt = '0;
                phase_nxt     = (len == 16'd0) ? PH_EXCESS : PH_PATH_LEN;
              end
            end
            PH_PATH_LEN: begin
              if (len == 16'd0 || len > PATH_MAX_BYTES) begin
                fail = 1'b1;
              end else begin
                field_len_nxt = len;
                verdict_nxt   = V_OPEN;
                phase_nxt     = PH_PATH;
              end
            end
            default: begin
              if (len == 16'd0 || len > KEY_MAX_BYTES) begin
                fail = 1'b1;
              end else begin
                field_len_nxt = len;
                phase_nxt     = PH_KEY;
              end
            end
          endcase
        end
      end
      PH_NAME: begin
        if (bif_inc >= field_len_r) begin
          phase_nxt = PH_COUNT;
          bif_nxt   = '0;
        end else begin
          bif_nxt = bif_inc;
        end
      end
      PH_PATH: begin
        store_we = (bif_r < STORE_LIMIT);
        if (bif_inc < field_len_r) begin
          bif_nxt     = bif_inc;
          verdict_nxt = v_mid;
        end else begin
          // Path still undecided at its end is a prefix or equal: both fail
          verdict_nxt = (v_mid == V_OPEN) ? V_EQUAL : v_mid;
          if (prior_len_r != 8'h00 && v_mid != V_GREATER) begin
            fail = 1'b1;
          end else begin
            prior_len_nxt = (field_len_r > STORE_LIMIT) ? STORE_LIMIT[7:0]
                                                        : field_len_r[7:0];
            phase_nxt     = PH_KEY_LEN;
            bif_nxt       = '0;
          end
        end
      end
      PH_KEY: begin
        if (bif_inc >= field_len_r) begin
          phase_nxt = PH_SIZE;
          bif_nxt   = '0;
        end else begin
          bif_nxt = bif_inc;
        end
      end
      PH_SIZE: begin
        if (bif_inc >= SIZE_BYTES) begin
          phase_nxt = PH_CID;
          bif_nxt   = '0;
        end else begin
          bif_nxt = bif_inc;
        end
      end
      PH_CID: begin
        if (bif_inc >= CID_BYTES) begin
          entry_cnt_nxt = entry_cnt_r + 9'd1;
          expected_nxt  = exp_dec;
          phase_nxt     = (exp_dec == 16'd0) ? PH_EXCESS : PH_PATH_LEN;
          bif_nxt       = '0;
        end else begin
          bif_nxt = bif_inc;
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase

    if (fail) begin
      error_nxt = 1'b1;
      phase_nxt = PH_EXCESS;
      bif_nxt   = '0;
    end

    status = error_nxt ? ST_ERROR : ST_OK;

    // Final byte: report the verdict and start over
    if (in_tlast) begin
      status        = (!error_nxt && phase_nxt == PH_EXCESS) ? ST_VALID : ST_ERROR;
      phase_nxt     = PH_MAGIC;
      bif_nxt       = '0;
      field_len_nxt = '0;
      expected_nxt  = '0;
      entry_cnt_nxt = '0;
      prior_len_nxt = '0;
      verdict_nxt   = V_OPEN;
      error_nxt     = 1'b0;
    end
  end

  // Read for the next byte follows the updated position
  assign store_raddr = accept ? bif_nxt[STORE_AW-1:0] : bif_r[STORE_AW-1:0];

  mfv_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_we),
    .waddr (bif_r[STORE_AW-1:0]),
    .wdata (b),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC;
      bif_r       <= '0;
      field_len_r <= '0;
      expected_r  <= '0;
      entry_cnt_r <= '0;
      prior_len_r <= '0;
      verdict_r   <= V_OPEN;
      error_r     <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      bif_r       <= bif_nxt;
      field_len_r <= field_len_nxt;
      expected_r  <= expected_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      prior_len_r <= prior_len_nxt;
      verdict_r   <= verdict_nxt;
      error_r     <= error_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {{(OUT_DATA_W - 18){1'b0}}, status, ent, b};
      out_user_r <= kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* hdl/mfv_ram.sv */
module mfv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/mfv_checker.sv */
module mfv_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [7:0]                     in_tdata,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mfv_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [mfv_pkg::OUT_USER_W-1:0] out_tuser
);

  import mfv_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Every accepted byte shows up as a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid && out_tdata[7:0] == $past(in_tdata))
    else $error("accepted byte did not appear as result");

  // A valid manifest ends on a count byte or a cid byte, and only on a final byte
  a_valid_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tdata[17:16] != ST_VALID ||
      ($past(in_tlast) && (out_tuser == KIND_COUNT || out_tuser == KIND_CID)))
    else $error("valid status at an impossible point");

  // Entry index is only shown within entries
  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser < KIND_PATH_LEN || out_tuser > KIND_CID) |->
      out_tdata[15:8] == 8'h00)
    else $error("entry index outside an entry");

  // Status code and field kind code range
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:16] != 2'd3 && out_tuser <= KIND_EXCESS)
    else $error("bad status or kind code");

endmodule

bind manifest_stream_validator mfv_checker u_mfv_checker (.*);

/* test/manifest_stream_validator_tb.sv */
`timescale 1ns / 1ps

module manifest_stream_validator_tb;
  import mfv_pkg::*;

  localparam logic [47:0] MAGIC_WORD = "M3REL1";
  localparam int          DIR_ROWS   = 22;
  localparam int          RAND_BYTES = 900;

  // Ways a generated manifest may be broken
  typedef enum int {
    FLAW_NONE,
    FLAW_CORRUPT,
    FLAW_TRUNCATE,
    FLAW_EXCESS,
    FLAW_NOISE,
    FLAW_NAME_ZERO,
    FLAW_NAME_OVER,
    FLAW_COUNT_OVER,
    FLAW_COUNT_MAX,
    FLAW_PATH_ZERO,
    FLAW_PATH_OVER,
    FLAW_KEY_ZERO,
    FLAW_KEY_OVER,
    FLAW_PATH_EQUAL,
    FLAW_PATH_LESS,
    FLAW_KINDS
  } flaw_e;

  // One result as the block reports it
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] value;
    logic [7:0] entry;
    logic [1:0] status;
  } byte_tag_t;

  // Directed row: byte, last flag, expected kind and status
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic [3:0] kind;
    logic [1:0] status;
  } dir_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = 8'h00;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  manifest_stream_validator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed rows: bad first byte, excess after error, shortest valid
  // manifest with extreme version bytes, then a manifest cut after one byte
  dir_row_t directed_rows [0:DIR_ROWS-1] = '{
    {8'hFF, 1'b0, KIND_MAGIC,    ST_ERROR},
    {8'h00, 1'b1, KIND_EXCESS,   ST_ERROR},
    {8'h4D, 1'b0, KIND_MAGIC,    ST_OK},
    {8'h33, 1'b0, KIND_MAGIC,    ST_OK},
    {8'h52, 1'b0, KIND_MAGIC,    ST_OK},
    {8'h45, 1'b0, KIND_MAGIC,    ST_OK},
    {8'h4C, 1'b0, KIND_MAGIC,    ST_OK},
    {8'h31, 1'b0, KIND_MAGIC,    ST_OK},
    {8'h00, 1'b0, KIND_VERSION,  ST_OK},
    {8'hFF, 1'b0, KIND_VERSION,  ST_OK},
    {8'h00, 1'b0, KIND_VERSION,  ST_OK},
    {8'hFF, 1'b0, KIND_VERSION,  ST_OK},
    {8'h80, 1'b0, KIND_VERSION,  ST_OK},
    {8'h01, 1'b0, KIND_VERSION,  ST_OK},
    {8'h7F, 1'b0, KIND_VERSION,  ST_OK},
    {8'hFE, 1'b0, KIND_VERSION,  ST_OK},
    {8'h00, 1'b0, KIND_NAME_LEN, ST_OK},
    {8'h01, 1'b0, KIND_NAME_LEN, ST_OK},
    {8'hFF, 1'b0, KIND_NAME,     ST_OK},
    {8'h00, 1'b0, KIND_COUNT,    ST_OK},
    {8'h00, 1'b1, KIND_COUNT,    ST_VALID},
    {8'h4D, 1'b1, KIND_MAGIC,    ST_ERROR}
  };

  // Parser state mirrored by the predictor
  logic [3:0]  parse_phase;
  logic [15:0] parse_pos;
  logic [15:0] parse_flen;
  logic [15:0] parse_remain;
  logic [8:0]  parse_entry;
  logic [7:0]  parse_path [0:STORE_DEPTH-1];
  logic [7:0]  parse_prev_len;
  verdict_t    parse_order;
  logic        parse_err;

  byte_tag_t   expected_tags [$];
  logic [7:0]  frame_q [$];

  int fails        = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int valid_ends   = 0;
  int error_ends   = 0;
  int burst_left   = 0;
  int stall_mode   = 0;
  int stall_left   = 0;

  task automatic clear_parser();
    parse_phase    = KIND_MAGIC;
    parse_pos      = '0;
    parse_flen     = '0;
    parse_remain   = '0;
    parse_entry    = '0;
    parse_prev_len = '0;
    parse_order    = V_OPEN;
    parse_err      = 1'b0;
  endtask

  task automatic parse_fail();
    parse_err   = 1'b1;
    parse_phase = KIND_EXCESS;
    parse_pos   = '0;
  endtask

  task automatic enter_field(input logic [3:0] next);
    parse_phase = next;
    parse_pos   = '0;
  endtask

  // Predict the tag of one manifest byte and advance the parser
  task automatic tag_byte(input logic [7:0] b, input logic eos, output byte_tag_t t);
    logic [15:0] len;
    logic [7:0]  p;
    t.kind  = parse_phase;
    t.value = b;
    t.entry = (parse_phase >= KIND_PATH_LEN && parse_phase <= KIND_CID) ?
              parse_entry[7:0] : 8'h00;
    case (parse_phase)
      KIND_MAGIC: begin
        if (parse_pos >= MAGIC_LEN) parse_fail();
        else if (b != MAGIC_WORD[47 - 8*parse_pos -: 8]) parse_fail();
        else begin
          parse_pos = parse_pos + 16'd1;
          if (parse_pos == MAGIC_LEN) enter_field(KIND_VERSION);
        end
      end
      KIND_VERSION: begin
        parse_pos = parse_pos + 16'd1;
        if (parse_pos >= VERSION_BYTES) enter_field(KIND_NAME_LEN);
      end
      KIND_NAME_LEN, KIND_COUNT, KIND_PATH_LEN, KIND_KEY_LEN: begin
        if (parse_pos == 16'd0) begin
          parse_flen = {b, 8'h00};
          parse_pos  = 16'd1;
        end else begin
          // big-endian length complete: bound-check it
          len = {parse_flen[15:8], b};
          case (parse_phase)
            KIND_NAME_LEN: begin
              if (len == 16'd0 || len > NAME_MAX_BYTES) parse_fail();
              else begin
                parse_flen = len;
                enter_field(KIND_NAME);
              end
            end
            KIND_COUNT: begin
              if (len > MAX_ENTRIES) parse_fail();
              else begin
                parse_remain   = len;
                parse_entry    = '0;
                parse_prev_len = '0;
                enter_field(len == 16'd0 ? KIND_EXCESS : KIND_PATH_LEN);
              end
            end
            KIND_PATH_LEN: begin
              if (len == 16'd0 || len > PATH_MAX_BYTES) parse_fail();
              else begin
                parse_flen  = len;
                parse_order = V_OPEN;
                enter_field(KIND_PATH);
              end
            end
            default: begin
              if (len == 16'd0 || len > KEY_MAX_BYTES) parse_fail();
              else begin
                parse_flen = len;
                enter_field(KIND_KEY);
              end
            end
          endcase
        end
      end
      KIND_NAME: begin
        parse_pos = parse_pos + 16'd1;
        if (parse_pos >= parse_flen) enter_field(KIND_COUNT);
      end
      KIND_PATH: begin
        // compare against the prior path; missing bytes read as zero
        p = (parse_pos < parse_prev_len && parse_pos < STORE_LIMIT) ?
            parse_path[parse_pos] : 8'h00;
        if (parse_order == V_OPEN) begin
          if (b < p) parse_order = V_LESS;
          else if (b > p) parse_order = V_GREATER;
          else if (b == 8'h00) parse_order = V_EQUAL;
        end
        if (parse_pos < STORE_LIMIT) parse_path[parse_pos] = b;
        parse_pos = parse_pos + 16'd1;
        if (parse_pos >= parse_flen) begin
          // still tied: the prior path is longer only if it goes on non-zero
          if (parse_order == V_OPEN) begin
            if (parse_flen < parse_prev_len && parse_path[parse_flen] != 8'h00)
              parse_order = V_LESS;
            else
              parse_order = V_EQUAL;
          end
          if (parse_prev_len != 8'd0 && parse_order != V_GREATER) parse_fail();
          else begin
            parse_prev_len = (parse_flen > STORE_LIMIT) ? 8'hFF : parse_flen[7:0];
            enter_field(KIND_KEY_LEN);
          end
        end
      end
      KIND_KEY: begin
        parse_pos = parse_pos + 16'd1;
        if (parse_pos >= parse_flen) enter_field(KIND_SIZE);
      end
      KIND_SIZE: begin
        parse_pos = parse_pos + 16'd1;
        if (parse_pos >= SIZE_BYTES) enter_field(KIND_CID);
      end
      KIND_CID: begin
        parse_pos = parse_pos + 16'd1;
        if (parse_pos >= CID_BYTES) begin
          parse_entry  = parse_entry + 9'd1;
          parse_remain = parse_remain - 16'd1;
          enter_field(parse_remain == 16'd0 ? KIND_EXCESS : KIND_PATH_LEN);
        end
      end
      default: parse_fail();
    endcase
    t.status = parse_err ? ST_ERROR : ST_OK;
    if (eos) begin
      t.status = (!parse_err && parse_phase == KIND_EXCESS) ? ST_VALID : ST_ERROR;
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    fails++;
    if (fails <= 40)
      $display("tb: mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
               what, results_seen, want, got);
  endtask

  // Send one byte in bursts with random gaps; predict once accepted
  task automatic push_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input logic [3:0] want_kind, input logic [1:0] want_status);
    byte_tag_t t;
    int        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tag_byte(b, eos, t);
    if (typed) begin
      t.kind   = want_kind;
      t.status = want_status;
      t.entry  = 8'h00;
    end
    expected_tags.push_back(t);
    bytes_sent++;
    if (eos && t.status == ST_VALID) valid_ends++;
    if (eos && t.status == ST_ERROR) error_ends++;
  endtask

  // Hold off the sender until every request has its result back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_tags.size() != 0);
  endtask

  task automatic put16(input int v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  task automatic put_random(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  // Build one manifest into frame_q, well-formed unless a flaw is chosen
  task automatic build_manifest(input flaw_e flaw);
    int         nlen, cnt, j, k, e, plen, klen, cut;
    logic       plain;
    logic [7:0] prev [$];
    logic [7:0] cur [$];
    frame_q.delete();
    for (k = 0; k < MAGIC_LEN; k++) frame_q.push_back(MAGIC_WORD[47 - 8*k -: 8]);
    put_random(VERSION_BYTES);

    nlen = ($urandom_range(0, 9) == 0) ? NAME_MAX_BYTES : $urandom_range(1, 8);
    if (flaw == FLAW_NAME_ZERO) nlen = 0;
    if (flaw == FLAW_NAME_OVER) nlen = NAME_MAX_BYTES + 1;
    put16(nlen);
    put_random(nlen);

    // entry count; per-entry flaws land on entry j
    cnt = $urandom_range(0, 4);
    if (flaw >= FLAW_PATH_ZERO && cnt < 2) cnt = 2;
    j = (cnt == 0) ? -1 : $urandom_range((flaw >= FLAW_PATH_EQUAL) ? 1 : 0, cnt - 1);
    case (flaw)
      FLAW_COUNT_OVER: put16(MAX_ENTRIES + 1);
      FLAW_COUNT_MAX:  put16(MAX_ENTRIES);
      default:         put16(cnt);
    endcase

    for (int en = 0; en < cnt; en++) begin
      cur.delete();
      plain = !(en == j && (flaw == FLAW_PATH_EQUAL || flaw == FLAW_PATH_LESS));
      // prior path as compared: up to its first zero byte
      e = 0;
      while (e < prev.size() && prev[e] != 8'h00) e++;
      if (en == 0) begin
        plen = ($urandom_range(0, 11) == 0) ? PATH_MAX_BYTES : $urandom_range(1, 6);
        repeat (plen) cur.push_back(8'($urandom));
      end else if (!plain && flaw == FLAW_PATH_EQUAL) begin
        for (k = 0; k < e; k++) cur.push_back(prev[k]);
        if (cur.size() == 0 || $urandom_range(0, 1) == 1) begin
          cur.push_back(8'h00);
          repeat ($urandom_range(0, 3)) cur.push_back(8'($urandom));
        end
      end else if (!plain) begin
        // below the prior path: a proper prefix or a lower first byte
        if (e >= 2 && $urandom_range(0, 1) == 1) begin
          for (k = 0; k < e - 1; k++) cur.push_back(prev[k]);
        end else begin
          cur.push_back((prev[0] == 8'h00) ? 8'h00 : 8'($urandom_range(0, prev[0] - 1)));
          repeat ($urandom_range(0, 4)) cur.push_back(8'($urandom));
        end
      end else begin
        // above the prior path: extend its prefix or raise one byte
        k = (e == 0) ? 0 : $urandom_range(0, e - 1);
        if (e == 0 || $urandom_range(0, 1) == 1 || prev[k] == 8'hFF) begin
          for (cut = 0; cut < e; cut++) cur.push_back(prev[cut]);
          repeat ($urandom_range(1, 4)) cur.push_back(8'($urandom_range(1, 255)));
        end else begin
          for (cut = 0; cut < k; cut++) cur.push_back(prev[cut]);
          cur.push_back(8'($urandom_range(prev[k] + 1, 255)));
          repeat ($urandom_range(0, 4)) cur.push_back(8'($urandom));
        end
      end
      // zero terminator with junk behind it
      if (plain && $urandom_range(0, 5) == 0) begin
        cur.push_back(8'h00);
        repeat ($urandom_range(0, 3)) cur.push_back(8'($urandom));
      end
      while (cur.size() > PATH_MAX_BYTES) void'(cur.pop_back());
      if (en == j && flaw == FLAW_PATH_OVER)
        while (cur.size() <= PATH_MAX_BYTES) cur.push_back(8'($urandom));

      if (en == j && flaw == FLAW_PATH_ZERO) put16(0);
      else put16(cur.size());
      for (k = 0; k < cur.size(); k++) frame_q.push_back(cur[k]);
      prev = cur;

      klen = ($urandom_range(0, 11) == 0) ? KEY_MAX_BYTES : $urandom_range(1, 6);
      if (en == j && flaw == FLAW_KEY_ZERO) klen = 0;
      if (en == j && flaw == FLAW_KEY_OVER) klen = KEY_MAX_BYTES + 1;
      put16(klen);
      put_random(klen);
      put_random(SIZE_BYTES);
      put_random(CID_BYTES);
    end

    // whole-frame damage
    case (flaw)
      FLAW_EXCESS:  put_random($urandom_range(1, 3));
      FLAW_CORRUPT: frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
      FLAW_TRUNCATE: begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      FLAW_NOISE: begin
        frame_q.delete();
        put_random($urandom_range(1, 20));
      end
      default: ;
    endcase
  endtask

  // Result checker and receiver stall pattern
  always @(posedge clk) begin : result_check
    byte_tag_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tags.size() == 0) begin
        report_mismatch("unexpected result", 0, out_tdata);
      end else begin
        want = expected_tags.pop_front();
        if (out_tuser != want.kind) report_mismatch("field_kind", want.kind, out_tuser);
        if (out_tdata[7:0] != want.value)
          report_mismatch("byte_value", want.value, out_tdata[7:0]);
        if (out_tdata[15:8] != want.entry)
          report_mismatch("entry_number", want.entry, out_tdata[15:8]);
        if (out_tdata[17:16] != want.status)
          report_mismatch("status", want.status, out_tdata[17:16]);
        if (out_tdata[OUT_DATA_W-1:18] != '0)
          report_mismatch("padding", 0, out_tdata[OUT_DATA_W-1:18]);
        results_seen++;
      end
    end
    // stretches of always-ready, light, heavy and near-total stalls
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin : stimulus
    int    i;
    int    manifests;
    flaw_e flaw;
    clear_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      push_byte(directed_rows[i].value, directed_rows[i].last, 1'b1,
                directed_rows[i].kind, directed_rows[i].status);
    drain();

    // every flaw once, then mostly well-formed manifests
    manifests = 0;
    while (bytes_sent < DIR_ROWS + RAND_BYTES || manifests < FLAW_KINDS) begin
      if (manifests < FLAW_KINDS) flaw = flaw_e'(manifests);
      else if ($urandom_range(0, 9) < 7) flaw = FLAW_NONE;
      else flaw = flaw_e'($urandom_range(1, FLAW_KINDS - 1));
      build_manifest(flaw);
      for (i = 0; i < frame_q.size(); i++)
        push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, KIND_MAGIC, ST_OK);
      manifests++;
      if (manifests % 4 == 0) drain();
    end
    drain();
    repeat (8) @(posedge clk);

    $display("tb: %0d generated manifests plus directed rows, %0d bytes, %0d results checked",
             manifests, bytes_sent, results_seen);
    $display("tb: %0d manifests closed valid, %0d closed with an integrity error",
             valid_ends, error_ends);
    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
hdl/mfv_pkg.sv
hdl/mfv_ram.sv
hdl/manifest_stream_validator.sv
hdl/mfv_checker.sv
test/manifest_stream_validator_tb.sv
